### rtl/ldet_pkg.sv
// ============================================================================
// ldet_pkg
// Shared constants and types of the Leibniz determinant block.
// ============================================================================
package ldet_pkg;

    localparam int MaxOrderDef   = 7;
    localparam int EntryWidthDef = 8;

    localparam int DataWidth     = 64;
    localparam int InWidth       = 8;
    localparam int OrderCfgWidth = 3;
    localparam int ApbAddrWidth  = 3;
    localparam int ApbDataWidth  = 32;

    localparam logic [OrderCfgWidth-1:0] OrderReset = 3'd3;

    // register indexes (word address bit of paddr)
    localparam logic RegMatrixOrder = 1'b0;

    typedef struct packed {
        logic restart;
        logic step;
    } perm_ctrl_t;

    typedef struct packed {
        logic odd;
        logic last;
    } perm_status_t;

endpackage

### rtl/ldet_store.sv
// ============================================================================
// ldet_store
// Matrix entry memory, one write port, one registered read port.
// ============================================================================
module ldet_store #(
    parameter int MAX_ORDER   = ldet_pkg::MaxOrderDef,
    parameter int ENTRY_WIDTH = ldet_pkg::EntryWidthDef
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [$clog2(MAX_ORDER*MAX_ORDER)-1:0]   wr_addr,
    input  logic [ENTRY_WIDTH-1:0]                   wr_data,
    input  logic [$clog2(MAX_ORDER*MAX_ORDER)-1:0]   rd_addr,
    output logic [ENTRY_WIDTH-1:0]                   rd_data
);

    localparam int Depth = MAX_ORDER * MAX_ORDER;

    logic [ENTRY_WIDTH-1:0] mem [Depth];
    logic [ENTRY_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/ldet_perm.sv
// ============================================================================
// ldet_perm
// Permutation sequencer: factorial-base digit counter, column pick for the
// current row and inversion parity of the current permutation.
// ============================================================================
module ldet_perm #(
    parameter int MAX_ORDER = ldet_pkg::MaxOrderDef
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  ldet_pkg::perm_ctrl_t               ctrl,
    input  logic [$clog2(MAX_ORDER+1)-1:0]     order,
    input  logic [$clog2(MAX_ORDER+1)-1:0]     row,
    input  logic [MAX_ORDER-1:0]               used,
    output logic [$clog2(MAX_ORDER)-1:0]       col,
    output ldet_pkg::perm_status_t             status
);

    localparam int OrderW = $clog2(MAX_ORDER + 1);
    localparam int ColW   = $clog2(MAX_ORDER);

    logic [ColW-1:0] digit_reg  [MAX_ORDER];
    logic [ColW-1:0] digit_next [MAX_ORDER];
    logic [ColW-1:0] digit_inc  [MAX_ORDER];
    logic [ColW-1:0] row_digit;
    logic            carry;

    // digit of the current row
    always_comb
    begin
        row_digit = '0;
        for (int i = 0; i < MAX_ORDER; i++)
        begin
            if (row == OrderW'(i))
            begin
                row_digit = digit_reg[i];
            end
        end
    end

    // pick the row_digit-th free column
    always_comb
    begin
        int  zeros;
        logic found;
        zeros = 0;
        found = 1'b0;
        col   = '0;
        for (int c = 0; c < MAX_ORDER; c++)
        begin
            if (!found && !used[c])
            begin
                if (zeros == int'(row_digit))
                begin
                    col   = ColW'(c);
                    found = 1'b1;
                end
                zeros++;
            end
        end
    end

    // odometer step, last digit moves fastest
    always_comb
    begin
        carry = 1'b1;
        for (int r = MAX_ORDER - 1; r >= 0; r--)
        begin
            digit_inc[r] = digit_reg[r];
            if (carry && (r < int'(order) - 1))
            begin
                if (int'(digit_reg[r]) == int'(order) - 1 - r)
                begin
                    digit_inc[r] = '0;
                end
                else
                begin
                    digit_inc[r] = digit_reg[r] + ColW'(1);
                    carry        = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        for (int r = 0; r < MAX_ORDER; r++)
        begin
            if (ctrl.restart)
            begin
                digit_next[r] = '0;
            end
            else if (ctrl.step)
            begin
                digit_next[r] = digit_inc[r];
            end
            else
            begin
                digit_next[r] = digit_reg[r];
            end
        end
    end

    // sum of the digits is the inversion count
    always_comb
    begin
        status.odd = 1'b0;
        for (int r = 0; r < MAX_ORDER; r++)
        begin
            status.odd = status.odd ^ digit_reg[r][0];
        end
        status.last = carry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < MAX_ORDER; r++)
            begin
                digit_reg[r] <= '0;
            end
        end
        else
        begin
            for (int r = 0; r < MAX_ORDER; r++)
            begin
                digit_reg[r] <= digit_next[r];
            end
        end
    end

endmodule

### rtl/leibniz_determinant.sv
// ============================================================================
// leibniz_determinant
// Loads a square matrix row-major, one signed entry per request, then sums
// the signed products of all permutations with one shared multiplier.
// ============================================================================
//  channel   signals                               direction
//  request   start, busy, entry_value              in/out
//  result    done, determinant                     out
//  config    psel, penable, pwrite, paddr, pwdata, in/out
//            prdata, pready
//
//  a load request writes one entry; the last of n*n entries starts the sum
//  the sum steps through all n! permutations: per permutation n reads of the
//  entry memory overlapped with the multiplier, then an accumulate state
//  done strobes for one cycle after the sum; busy is high while summing
//  the receiver cannot stall; determinant is held from the done cycle until the next result
//  reset clears the load count and the sum; order resets to 3
// ============================================================================
module leibniz_determinant #(
    parameter int MAX_ORDER   = ldet_pkg::MaxOrderDef,
    parameter int ENTRY_WIDTH = ldet_pkg::EntryWidthDef
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic signed [ldet_pkg::InWidth-1:0]     entry_value,
    output logic                                    done,
    output logic signed [ldet_pkg::DataWidth-1:0]   determinant,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [ldet_pkg::ApbAddrWidth-1:0]       paddr,
    input  logic [ldet_pkg::ApbDataWidth-1:0]       pwdata,
    output logic [ldet_pkg::ApbDataWidth-1:0]       prdata,
    output logic                                    pready
);

    localparam int OrderW = $clog2(MAX_ORDER + 1);
    localparam int ColW   = $clog2(MAX_ORDER);
    localparam int Depth  = MAX_ORDER * MAX_ORDER;
    localparam int AddrW  = $clog2(Depth);
    localparam int BaseW  = $clog2(Depth + 1);
    localparam int TotW   = 2 * OrderW;
    localparam int DataW  = ldet_pkg::DataWidth;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_ACC
    } state_t;

    state_t                            state_reg,     state_next;
    logic [ldet_pkg::OrderCfgWidth-1:0] order_reg,    order_next;
    logic [AddrW-1:0]                  load_cnt_reg,  load_cnt_next;
    logic [OrderW-1:0]                 row_reg,       row_next;
    logic [BaseW-1:0]                  base_reg,      base_next;
    logic [MAX_ORDER-1:0]              used_reg,      used_next;
    logic                              pend_reg,      pend_next;
    logic [DataW-1:0]                  prod_reg,      prod_next;
    logic [DataW-1:0]                  sum_reg,       sum_next;
    logic [DataW-1:0]                  det_reg,       det_next;
    logic                              done_reg,      done_next;

    logic [OrderW-1:0]                 eff_order;
    logic [TotW-1:0]                   total;
    logic                              req_accept;
    logic                              cfg_write;
    logic                              issue;
    logic [BaseW-1:0]                  addr_sum;
    logic [AddrW-1:0]                  rd_addr;
    logic [ENTRY_WIDTH-1:0]            rd_data;
    logic [ColW-1:0]                   col;
    logic signed [DataW+ENTRY_WIDTH-1:0] mul_full;
    logic [DataW-1:0]                  acc;
    ldet_pkg::perm_ctrl_t              perm_ctrl;
    ldet_pkg::perm_status_t            perm_status;

    always_comb
    begin
        if (order_reg == '0)
        begin
            eff_order = OrderW'(1);
        end
        else if (int'(order_reg) > MAX_ORDER)
        begin
            eff_order = OrderW'(MAX_ORDER);
        end
        else
        begin
            eff_order = OrderW'(order_reg);
        end
    end

    assign total      = TotW'(eff_order) * TotW'(eff_order);
    assign busy       = (state_reg != S_IDLE);
    assign req_accept = start && !busy;
    assign cfg_write  = psel && penable && pwrite && pready;
    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == ldet_pkg::RegMatrixOrder)
                        ? ldet_pkg::ApbDataWidth'(order_reg) : '0;

    assign issue    = (row_reg < eff_order);
    assign addr_sum = base_reg + BaseW'(col);
    assign rd_addr  = addr_sum[AddrW-1:0];
    assign mul_full = $signed(prod_reg) * $signed(rd_data);
    assign acc      = perm_status.odd ? (sum_reg - prod_reg) : (sum_reg + prod_reg);

    ldet_store #(
        .MAX_ORDER   (MAX_ORDER),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (req_accept),
        .wr_addr (load_cnt_reg),
        .wr_data (entry_value[ENTRY_WIDTH-1:0]),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ldet_perm #(
        .MAX_ORDER (MAX_ORDER)
    ) u_perm (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (perm_ctrl),
        .order  (eff_order),
        .row    (row_reg),
        .used   (used_reg),
        .col    (col),
        .status (perm_status)
    );

    always_comb
    begin
        state_next        = state_reg;
        order_next        = order_reg;
        load_cnt_next     = load_cnt_reg;
        row_next          = row_reg;
        base_next         = base_reg;
        used_next         = used_reg;
        pend_next         = pend_reg;
        prod_next         = prod_reg;
        sum_next          = sum_reg;
        det_next          = det_reg;
        done_next         = 1'b0;
        perm_ctrl.restart = 1'b0;
        perm_ctrl.step    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_write && (paddr[2] == ldet_pkg::RegMatrixOrder))
                begin
                    order_next    = pwdata[ldet_pkg::OrderCfgWidth-1:0];
                    load_cnt_next = '0;
                    sum_next      = '0;
                end
                else if (req_accept)
                begin
                    if ((TotW'(load_cnt_reg) + TotW'(1)) >= total)
                    begin
                        load_cnt_next     = '0;
                        row_next          = '0;
                        base_next         = '0;
                        used_next         = '0;
                        pend_next         = 1'b0;
                        prod_next         = DataW'(1);
                        sum_next          = '0;
                        perm_ctrl.restart = 1'b1;
                        state_next        = S_RUN;
                    end
                    else
                    begin
                        load_cnt_next = load_cnt_reg + AddrW'(1);
                    end
                end
            end

            S_RUN:
            begin
                if (pend_reg)
                begin
                    prod_next = mul_full[DataW-1:0];
                end
                if (issue)
                begin
                    used_next = used_reg | (MAX_ORDER'(1) << col);
                    base_next = base_reg + BaseW'(eff_order);
                    row_next  = row_reg + OrderW'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_ACC;
                end
            end

            S_ACC:
            begin
                perm_ctrl.step = 1'b1;
                row_next       = '0;
                base_next      = '0;
                used_next      = '0;
                prod_next      = DataW'(1);
                if (perm_status.last)
                begin
                    det_next   = acc;
                    done_next  = 1'b1;
                    sum_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    sum_next   = acc;
                    state_next = S_RUN;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            order_reg    <= ldet_pkg::OrderReset;
            load_cnt_reg <= '0;
            row_reg      <= '0;
            base_reg     <= '0;
            used_reg     <= '0;
            pend_reg     <= 1'b0;
            prod_reg     <= '0;
            sum_reg      <= '0;
            det_reg      <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            order_reg    <= order_next;
            load_cnt_reg <= load_cnt_next;
            row_reg      <= row_next;
            base_reg     <= base_next;
            used_reg     <= used_next;
            pend_reg     <= pend_next;
            prod_reg     <= prod_next;
            sum_reg      <= sum_next;
            det_reg      <= det_next;
            done_reg     <= done_next;
        end
    end

    assign done        = done_reg;
    assign determinant = det_reg;

    // result only follows the final accumulate
    a_done_after_acc: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == S_ACC))
        else $error("result strobe without final accumulate");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe longer than one cycle");

    // one column taken per fetched row
    a_used_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> ($countones(used_reg) == int'(row_reg)))
        else $error("column mask out of step with row count");

    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (row_reg <= eff_order))
        else $error("row count past matrix order");

endmodule
